// ===== rtl/pdpm_pkg.sv =====
// shared widths, constants and codes of the pwm duty and period meter
package pdpm_pkg;

  localparam int PPW_W     = 10;
  localparam int SP_W      = 24;
  localparam int EDGE_W    = 11;
  localparam int OUT_CNT_W = 32;
  localparam int PERIOD_W  = 48;
  localparam int FREQ_W    = 40;
  localparam int DUTY_W    = 14;

  localparam logic [PPW_W-1:0]  PPW_RESET     = 10'd100;
  localparam logic [SP_W-1:0]   SP_RESET      = 24'd1282050;
  localparam logic [EDGE_W-1:0] EDGE_MAX      = 11'd2047;
  localparam logic [FREQ_W-1:0] PS_PER_SECOND = 40'd1000000000000;
  localparam logic [SP_W-1:0]   DUTY_SCALE    = 24'd10000;
  localparam logic [DUTY_W-1:0] DUTY_FULL     = 14'd10000;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CFG_PPW       = 1'b0,
    CFG_SAMPLE_PS = 1'b1
  } cfg_index_e;

endpackage

// ===== rtl/pwm_duty_period_meter.sv =====
// Each window record leaves the queue for the shared shift-add and divide: multiply and divide
//   for the period, divide for the frequency, multiply and divide for the duty, then registered.
// Throughput: one pin sample per cycle; the front stalls only while two closed windows wait.
// The single back-end divider takes one window record at a time, up to its registered result.
// Reset: asynchronous, clears counters, edge state, queue and output; registers to defaults.
module pwm_duty_period_meter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  pdpm_pkg::cfg_index_e            cfg_index_i,
  input  logic [pdpm_pkg::SP_W-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            pin_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pdpm_pkg::OUT_CNT_W-1:0]  high_samples_o,
  output logic [pdpm_pkg::OUT_CNT_W-1:0]  low_samples_o,
  output logic [pdpm_pkg::PERIOD_W-1:0]   period_ps_o,
  output logic [pdpm_pkg::FREQ_W-1:0]     frequency_hz_o,
  output logic [pdpm_pkg::DUTY_W-1:0]     duty_centipercent_o,
  output logic                            count_saturated_o
);
  import pdpm_pkg::*;

  localparam int REC_W = 2 * COUNT_WIDTH + 1 + PPW_W + SP_W;

  logic [PPW_W-1:0]       ppw_q;
  logic [SP_W-1:0]        sample_ps_q;

  logic                   push, q_full, q_valid, q_pop;
  logic [COUNT_WIDTH-1:0] f_high, f_low, b_high, b_low;
  logic                   f_sat, b_sat;
  logic [PPW_W-1:0]       f_ppw, b_ppw;
  logic [SP_W-1:0]        f_sp, b_sp;
  logic [REC_W-1:0]       q_din, q_dout;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppw_q       <= PPW_RESET;
      sample_ps_q <= SP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PPW:       ppw_q       <= cfg_data_i[PPW_W-1:0];
        CFG_SAMPLE_PS: sample_ps_q <= cfg_data_i;
      endcase
    end
  end

  pdpm_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .pin_level_i     (pin_level_i),
    .in_stall_o      (in_stall_o),
    .ppw_i           (ppw_q),
    .sample_ps_i     (sample_ps_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .rec_high_o      (f_high),
    .rec_low_o       (f_low),
    .rec_sat_o       (f_sat),
    .rec_ppw_o       (f_ppw),
    .rec_sample_ps_o (f_sp)
  );

  assign q_din = {f_high, f_low, f_sat, f_ppw, f_sp};

  pdpm_queue #(.WIDTH(REC_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_dout)
  );

  assign {b_high, b_low, b_sat, b_ppw, b_sp} = q_dout;

  pdpm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_valid_i           (q_valid),
    .q_pop_o             (q_pop),
    .rec_high_i          (b_high),
    .rec_low_i           (b_low),
    .rec_sat_i           (b_sat),
    .rec_ppw_i           (b_ppw),
    .rec_sample_ps_i     (b_sp),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .high_samples_o      (high_samples_o),
    .low_samples_o       (low_samples_o),
    .period_ps_o         (period_ps_o),
    .frequency_hz_o      (frequency_hz_o),
    .duty_centipercent_o (duty_centipercent_o),
    .count_saturated_o   (count_saturated_o)
  );

endmodule

// ===== rtl/pdpm_front.sv =====
// front end: edge detection, sample counting and window close
module pdpm_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          pin_level_i,
  output logic                          in_stall_o,
  input  logic [pdpm_pkg::PPW_W-1:0]    ppw_i,
  input  logic [pdpm_pkg::SP_W-1:0]     sample_ps_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output logic [COUNT_WIDTH-1:0]        rec_high_o,
  output logic [COUNT_WIDTH-1:0]        rec_low_o,
  output logic                          rec_sat_o,
  output logic [pdpm_pkg::PPW_W-1:0]    rec_ppw_o,
  output logic [pdpm_pkg::SP_W-1:0]     rec_sample_ps_o
);
  import pdpm_pkg::*;

  logic                   ref_q, ref_d;
  logic                   started_q, started_d;
  logic                   watch_q, watch_d;
  logic [EDGE_W-1:0]      edge_cnt_q, edge_cnt_d;
  logic [COUNT_WIDTH-1:0] high_q, high_d;
  logic [COUNT_WIDTH-1:0] low_q, low_d;
  logic                   sat_q, sat_d;

  logic                   accept;
  logic                   edge_hit;
  logic                   win_end;
  logic                   tally;
  logic [PPW_W-1:0]       ppw_eff;
  logic [EDGE_W-1:0]      edge_limit;
  logic [EDGE_W-1:0]      edge_inc;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // a zero window length behaves as one period
  assign ppw_eff    = (ppw_i == '0) ? PPW_W'(1) : ppw_i;
  assign edge_limit = {ppw_eff, 1'b0};
  assign edge_hit   = (pin_level_i == watch_q);
  assign edge_inc   = (edge_hit && edge_cnt_q != EDGE_MAX) ? edge_cnt_q + 1'b1 : edge_cnt_q;
  assign win_end    = accept & ref_q & started_q & (edge_inc >= edge_limit);

  assign push_o          = win_end;
  assign rec_high_o      = high_q;
  assign rec_low_o       = low_q;
  assign rec_sat_o       = sat_q;
  assign rec_ppw_o       = ppw_eff;
  assign rec_sample_ps_o = sample_ps_i;

  always_comb begin
    ref_d      = ref_q;
    started_d  = started_q;
    watch_d    = watch_q;
    edge_cnt_d = edge_cnt_q;
    high_d     = high_q;
    low_d      = low_q;
    sat_d      = sat_q;
    tally      = 1'b0;
    if (accept) begin
      if (!ref_q) begin
        ref_d   = 1'b1;
        watch_d = pin_level_i;
      end else if (!started_q) begin
        if (pin_level_i != watch_q) begin
          started_d  = 1'b1;
          edge_cnt_d = '0;
          tally      = 1'b1;
        end
      end else begin
        watch_d    = watch_q ^ edge_hit;
        edge_cnt_d = edge_inc;
        tally      = 1'b1;
        // closing sample opens the next window
        if (win_end) begin
          edge_cnt_d = '0;
          high_d     = '0;
          low_d      = '0;
          sat_d      = 1'b0;
        end
      end
    end
    if (tally) begin
      if (pin_level_i) begin
        if (&high_d) sat_d = 1'b1;
        else         high_d = high_d + 1'b1;
      end else begin
        if (&low_d) sat_d = 1'b1;
        else        low_d = low_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q      <= 1'b0;
      started_q  <= 1'b0;
      watch_q    <= 1'b0;
      edge_cnt_q <= '0;
      high_q     <= '0;
      low_q      <= '0;
      sat_q      <= 1'b0;
    end else begin
      ref_q      <= ref_d;
      started_q  <= started_d;
      watch_q    <= watch_d;
      edge_cnt_q <= edge_cnt_d;
      high_q     <= high_d;
      low_q      <= low_d;
      sat_q      <= sat_d;
    end
  end

  a_push_clears_edges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (edge_cnt_q == '0))
    else $error("edge count not cleared after window close");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("counting dropped out of started state");

endmodule

// ===== rtl/pdpm_queue.sv =====
// short queue of closed window records between front and back
module pdpm_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import pdpm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

endmodule

// ===== rtl/pdpm_back.sv =====
// back end: period, frequency and duty from one window record, shift-add and restoring divide
module pdpm_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_pop_o,
  input  logic [COUNT_WIDTH-1:0]          rec_high_i,
  input  logic [COUNT_WIDTH-1:0]          rec_low_i,
  input  logic                            rec_sat_i,
  input  logic [pdpm_pkg::PPW_W-1:0]      rec_ppw_i,
  input  logic [pdpm_pkg::SP_W-1:0]       rec_sample_ps_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pdpm_pkg::OUT_CNT_W-1:0]  high_samples_o,
  output logic [pdpm_pkg::OUT_CNT_W-1:0]  low_samples_o,
  output logic [pdpm_pkg::PERIOD_W-1:0]   period_ps_o,
  output logic [pdpm_pkg::FREQ_W-1:0]     frequency_hz_o,
  output logic [pdpm_pkg::DUTY_W-1:0]     duty_centipercent_o,
  output logic                            count_saturated_o
);
  import pdpm_pkg::*;

  localparam int CW     = COUNT_WIDTH;
  localparam int TOT_W  = CW + 1;
  localparam int PW     = (CW + SP_W + 1 > PERIOD_W + 1) ? CW + SP_W + 1 : PERIOD_W + 1;
  localparam int DW     = (TOT_W > PERIOD_W) ? TOT_W : PERIOD_W;
  localparam int STEP_W = $clog2(PW);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_e;
  typedef enum logic [1:0] {OP_PERIOD, OP_FREQ, OP_DUTY} op_e;

  state_e              state_q;
  op_e                 op_q;
  logic [STEP_W-1:0]   step_q;
  logic [PW-1:0]       acc_q;
  logic [PW-1:0]       mcand_q;
  logic [SP_W-1:0]     mplier_q;
  logic [DW-1:0]       rem_q;
  logic [DW-1:0]       div_q;
  logic [CW-1:0]       high_q, low_q;
  logic                sat_q;
  logic [PERIOD_W-1:0] period_q;
  logic [FREQ_W-1:0]   freq_q;
  logic [DUTY_W-1:0]   duty_q;

  logic                 out_valid_q;
  logic [OUT_CNT_W-1:0] out_high_q, out_low_q;
  logic [PERIOD_W-1:0]  out_period_q;
  logic [FREQ_W-1:0]    out_freq_q;
  logic [DUTY_W-1:0]    out_duty_q;
  logic                 out_sat_q;

  logic [TOT_W-1:0]    rec_total, cur_total;
  logic [PW-1:0]       mul_next;
  logic [DW:0]         rem_shift;
  logic                rem_ge;
  logic [DW-1:0]       rem_next;
  logic [PW-1:0]       quo_next;
  logic                div_zero;
  logic [PERIOD_W-1:0] period_val;
  logic                hi_over, lo_over;
  logic                out_taken, out_free;

  assign rec_total = TOT_W'(rec_high_i) + TOT_W'(rec_low_i);
  assign cur_total = TOT_W'(high_q) + TOT_W'(low_q);

  // multiplier bits taken msb first
  assign mul_next  = {acc_q[PW-2:0], 1'b0} + (mplier_q[SP_W-1] ? mcand_q : '0);

  assign rem_shift = {rem_q, acc_q[PW-1]};
  assign rem_ge    = (rem_shift >= {1'b0, div_q});
  assign rem_next  = rem_ge ? DW'(rem_shift - {1'b0, div_q}) : rem_shift[DW-1:0];
  assign quo_next  = {acc_q[PW-2:0], rem_ge};
  assign div_zero  = (div_q == '0);

  always_comb begin
    if (div_zero)                   period_val = '0;
    else if (|quo_next[PW-1:PERIOD_W]) period_val = '1;
    else                            period_val = quo_next[PERIOD_W-1:0];
  end

  assign hi_over   = ((64'(high_q) >> OUT_CNT_W) != 64'd0);
  assign lo_over   = ((64'(low_q) >> OUT_CNT_W) != 64'd0);
  assign out_taken = out_valid_q & ~out_stall_i;
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign q_pop_o   = (state_q == ST_IDLE) & q_valid_i;

  assign out_valid_o         = out_valid_q;
  assign high_samples_o      = out_high_q;
  assign low_samples_o       = out_low_q;
  assign period_ps_o         = out_period_q;
  assign frequency_hz_o      = out_freq_q;
  assign duty_centipercent_o = out_duty_q;
  assign count_saturated_o   = out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_PERIOD;
      step_q       <= '0;
      acc_q        <= '0;
      mcand_q      <= '0;
      mplier_q     <= '0;
      rem_q        <= '0;
      div_q        <= '0;
      high_q       <= '0;
      low_q        <= '0;
      sat_q        <= 1'b0;
      period_q     <= '0;
      freq_q       <= '0;
      duty_q       <= '0;
      out_valid_q  <= 1'b0;
      out_high_q   <= '0;
      out_low_q    <= '0;
      out_period_q <= '0;
      out_freq_q   <= '0;
      out_duty_q   <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      if (out_taken) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            high_q   <= rec_high_i;
            low_q    <= rec_low_i;
            sat_q    <= rec_sat_i;
            mcand_q  <= PW'(rec_total);
            mplier_q <= rec_sample_ps_i;
            div_q    <= DW'(rec_ppw_i);
            acc_q    <= '0;
            step_q   <= '0;
            op_q     <= OP_PERIOD;
            state_q  <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_q    <= mul_next;
          mplier_q <= {mplier_q[SP_W-2:0], 1'b0};
          step_q   <= step_q + 1'b1;
          if (step_q == STEP_W'(SP_W - 1)) begin
            step_q  <= '0;
            rem_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          acc_q  <= quo_next;
          rem_q  <= rem_next;
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(PW - 1)) begin
            step_q <= '0;
            rem_q  <= '0;
            unique case (op_q)
              OP_PERIOD: begin
                period_q <= period_val;
                acc_q    <= PW'(PS_PER_SECOND);
                div_q    <= DW'(period_val);
                op_q     <= OP_FREQ;
              end
              OP_FREQ: begin
                freq_q   <= div_zero ? '0 : quo_next[FREQ_W-1:0];
                acc_q    <= '0;
                mcand_q  <= PW'(high_q);
                mplier_q <= DUTY_SCALE;
                div_q    <= DW'(cur_total);
                op_q     <= OP_DUTY;
                state_q  <= ST_MUL;
              end
              OP_DUTY: begin
                duty_q  <= div_zero ? '0 : quo_next[DUTY_W-1:0];
                state_q <= ST_DONE;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_high_q   <= hi_over ? '1 : OUT_CNT_W'(high_q);
            out_low_q    <= lo_over ? '1 : OUT_CNT_W'(low_q);
            out_period_q <= period_q;
            out_freq_q   <= freq_q;
            out_duty_q   <= duty_q;
            out_sat_q    <= sat_q | hi_over | lo_over;
            state_q      <= ST_IDLE;
          end
        end
      endcase
    end
  end

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (duty_centipercent_o <= DUTY_FULL))
    else $error("duty beyond full scale");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside the done state");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the pwm duty and period meter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pdpm_pkg::*;

  localparam int COUNT_WIDTH    = 32;
  localparam int PIPE_W         = (COUNT_WIDTH + 25 > 49) ? COUNT_WIDTH + 25 : 49;
  localparam int RESULT_LATENCY = 3 * PIPE_W + 50;
  localparam int SETTLE_CYCLES  = 2 * RESULT_LATENCY;
  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int RANDOM_ITEMS   = 300;
  localparam int REPORT_LIMIT   = 10;

  localparam bit [63:0] COUNT_LIMIT  = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam bit [63:0] OUT_LIMIT    = (64'd1 << OUT_CNT_W) - 64'd1;
  localparam bit [63:0] PERIOD_LIMIT = (64'd1 << PERIOD_W) - 64'd1;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] hi_samples;
    logic [OUT_CNT_W-1:0] lo_samples;
    logic [PERIOD_W-1:0]  period;
    logic [FREQ_W-1:0]    freq;
    logic [DUTY_W-1:0]    duty;
    logic                 sat;
  } meter_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  cfg_index_e           cfg_index_i = CFG_PPW;
  logic [SP_W-1:0]      cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic                 pin_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [OUT_CNT_W-1:0] high_samples_o;
  logic [OUT_CNT_W-1:0] low_samples_o;
  logic [PERIOD_W-1:0]  period_ps_o;
  logic [FREQ_W-1:0]    frequency_hz_o;
  logic [DUTY_W-1:0]    duty_centipercent_o;
  logic                 count_saturated_o;

  pwm_duty_period_meter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .pin_level_i        (pin_level_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .high_samples_o     (high_samples_o),
    .low_samples_o      (low_samples_o),
    .period_ps_o        (period_ps_o),
    .frequency_hz_o     (frequency_hz_o),
    .duty_centipercent_o(duty_centipercent_o),
    .count_saturated_o  (count_saturated_o)
  );

  // meter model state and register copies
  bit [PPW_W-1:0] ppw_reg = PPW_RESET;
  bit [SP_W-1:0]  sample_ps_reg = SP_RESET;
  bit             ref_taken;
  bit             counting;
  bit             watch_level;
  int             edges_seen;
  bit [63:0]      high_cnt;
  bit [63:0]      low_cnt;
  bit             sat_flag;

  meter_result_t  pending_windows[$];
  int             windows_predicted;
  int             fail_count;
  bit             burst_mode;
  logic           stream_level;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 120);
  endfunction

  function automatic void tally_sample(logic lvl);
    if (lvl) begin
      if (high_cnt < COUNT_LIMIT) high_cnt++;
      else sat_flag = 1'b1;
    end else begin
      if (low_cnt < COUNT_LIMIT) low_cnt++;
      else sat_flag = 1'b1;
    end
  endfunction

  function automatic meter_result_t window_summary();
    bit [63:0] ppw;
    bit [63:0] sp;
    bit [63:0] total;
    bit [63:0] quot;
    bit [63:0] rem;
    bit [63:0] period;
    bit [63:0] freq;
    bit [63:0] duty;
    meter_result_t res;
    ppw = (ppw_reg == '0) ? 64'd1 : 64'(ppw_reg);
    sp = 64'(sample_ps_reg);
    total = high_cnt + low_cnt;
    quot = total / ppw;
    rem = total % ppw;
    if (sp != 0 && quot > PERIOD_LIMIT / sp) begin
      period = PERIOD_LIMIT;
    end else begin
      period = quot * sp + (rem * sp) / ppw;
      if (period > PERIOD_LIMIT) period = PERIOD_LIMIT;
    end
    freq = (period != 0) ? 64'(PS_PER_SECOND) / period : 64'd0;
    duty = (total != 0) ? (high_cnt * 64'(DUTY_FULL)) / total : 64'd0;
    res.hi_samples = (high_cnt > OUT_LIMIT) ? OUT_LIMIT[OUT_CNT_W-1:0] : high_cnt[OUT_CNT_W-1:0];
    res.lo_samples = (low_cnt > OUT_LIMIT) ? OUT_LIMIT[OUT_CNT_W-1:0] : low_cnt[OUT_CNT_W-1:0];
    res.period = period[PERIOD_W-1:0];
    res.freq = freq[FREQ_W-1:0];
    res.duty = duty[DUTY_W-1:0];
    res.sat = sat_flag || high_cnt > OUT_LIMIT || low_cnt > OUT_LIMIT;
    return res;
  endfunction

  function automatic void predict_sample(logic lvl);
    int ppw;
    if (!ref_taken) begin
      ref_taken = 1'b1;
      watch_level = lvl;
    end else if (!counting) begin
      // nothing counts until the pin leaves its reference level
      if (lvl != watch_level) begin
        counting = 1'b1;
        edges_seen = 0;
        tally_sample(lvl);
      end
    end else begin
      if (lvl == watch_level) begin
        watch_level = ~watch_level;
        if (edges_seen < int'(EDGE_MAX)) edges_seen++;
      end
      ppw = (ppw_reg == '0) ? 1 : int'(ppw_reg);
      if (edges_seen >= 2 * ppw) begin
        pending_windows.push_back(window_summary());
        windows_predicted++;
        edges_seen = 0;
        high_cnt = '0;
        low_cnt = '0;
        sat_flag = 1'b0;
      end
      // the closing sample opens the next window
      tally_sample(lvl);
    end
  endfunction

  task automatic send_sample(input logic lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pin_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_sample(lvl);
  endtask

  task automatic send_bits(input logic [15:0] bits, input int count);
    for (int i = count - 1; i >= 0; i--) send_sample(bits[i]);
  endtask

  // well-formed pwm: alternating runs of random length
  task automatic send_pwm(input int count, input int max_high, input int max_low);
    int run;
    int sent;
    sent = 0;
    while (sent < count) begin
      stream_level = ~stream_level;
      run = stream_level ? $urandom_range(1, max_high) : $urandom_range(1, max_low);
      repeat (run) begin
        if (sent < count) begin
          send_sample(stream_level);
          sent++;
        end
      end
    end
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_sample(logic'($urandom_range(0, 1)));
  endtask

  // wait until every window has come out and the back end has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [PPW_W-1:0] ppw, input logic [SP_W-1:0] sp);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_PPW;
    cfg_data_i <= SP_W'(ppw);
    @(posedge clk_i);
    ppw_reg = ppw;
    cfg_index_i <= CFG_SAMPLE_PS;
    cfg_data_i <= sp;
    @(posedge clk_i);
    sample_ps_reg = sp;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_default_window();
    int target;
    target = windows_predicted + 1;
    // reference held for a while before the first change
    send_bits(16'b000, 3);
    stream_level = 1'b0;
    while (windows_predicted < target) send_pwm(8, 2, 2);
  endtask

  task automatic test_directed();
    // zero window length behaves as one, zero sample period gives zero frequency
    settle();
    write_config('0, '0);
    send_bits(16'b0011010, 7);
    settle();
    write_config(10'd1, '1);
    send_bits(16'b101001, 6);
    settle();
    write_config(10'd20, 24'd1);
    send_bits(16'b101010, 6);
    // shrink the window below its progress: next sample closes it
    settle();
    write_config(10'd1, 24'd1);
    send_bits(16'b1, 1);
    stream_level = 1'b1;
  endtask

  task automatic test_long_window();
    int target;
    settle();
    write_config(10'd60, '1);
    target = windows_predicted + 1;
    while (windows_predicted < target) send_pwm(64, 2, 2);
  endtask

  task automatic test_random_phases();
    int sent;
    int phase_sent;
    int phase_len;
    int chunk;
    int r;
    logic [PPW_W-1:0] ppw;
    logic [SP_W-1:0] sp;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      r = $urandom_range(0, 99);
      if (r < 50) ppw = PPW_W'($urandom_range(1, 4));
      else if (r < 80) ppw = PPW_W'($urandom_range(5, 16));
      else if (r < 90) ppw = '0;
      else ppw = PPW_W'($urandom_range(17, 40));
      r = $urandom_range(0, 99);
      if (r < 15) sp = '0;
      else if (r < 30) sp = '1;
      else if (r < 40) sp = 24'd1;
      else sp = SP_W'($urandom());
      burst_mode = ($urandom_range(0, 3) == 0);
      write_config(ppw, sp);
      phase_len = $urandom_range(60, 120);
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        r = $urandom_range(0, 99);
        chunk = $urandom_range(8, 30);
        if (r < 80) send_pwm(chunk, $urandom_range(1, 6), $urandom_range(1, 6));
        else if (r < 92) send_noise(chunk);
        else send_pwm(chunk, $urandom_range(1, 40), $urandom_range(1, 40));
        phase_sent += chunk;
      end
      sent += phase_sent;
    end
    burst_mode = 1'b0;
  endtask

  // receiver stalls
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left = pick_gap();
      end
    end
  end

  // compare each transfer on the result side with the oldest window waiting
  always @(posedge clk_i) begin
    meter_result_t got;
    meter_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {high_samples_o, low_samples_o, period_ps_o, frequency_hz_o,
             duty_centipercent_o, count_saturated_o};
      if (pending_windows.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("unexpected result: high %0d low %0d period %0d freq %0d duty %0d sat %0d",
                   got.hi_samples, got.lo_samples, got.period, got.freq, got.duty, got.sat);
      end else begin
        want = pending_windows.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $write("result mismatch (expected/actual): high %0d/%0d low %0d/%0d ",
                   want.hi_samples, got.hi_samples, want.lo_samples, got.lo_samples);
            $display("period %0d/%0d freq %0d/%0d duty %0d/%0d sat %0d/%0d",
                     want.period, got.period, want.freq, got.freq,
                     want.duty, got.duty, want.sat, got.sat);
          end
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_window();
    test_directed();
    test_long_window();
    test_random_phases();
    settle();
    if (fail_count == 0 && pending_windows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
